// File: src/bttm_pkg.sv
// Shared types and constants for the battery, temperature and button monitor.
// Holds the request and result structs, the register map and fixed-point constants.
// No dependencies; every other file of the block but bttm_ram imports this package.
package bttm_pkg;

    // Channel widths
    localparam int SAMPLE_W    = 12;
    localparam int THR_MV_W    = 15;
    localparam int THR_CNT_W   = 13;
    localparam int MV_W        = 15;
    localparam int LEVEL_W     = 3;
    localparam int CHARGE_W    = 2;
    localparam int TEMP_W      = 12;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 15;

    // Ring depths: defaults and the largest depth the sums are sized for
    localparam int BATT_SAMPLES_DEF = 8;
    localparam int TEMP_SAMPLES_DEF = 8;
    localparam int STAT_SAMPLES_DEF = 8;
    localparam int MAX_SAMPLES      = 64;
    localparam int SUM_W            = SAMPLE_W + $clog2(MAX_SAMPLES);

    // Averaging divide by ring depth: exact reciprocal multiply
    localparam int AVG_SHIFT   = SUM_W + $clog2(MAX_SAMPLES);
    localparam int AVG_RECIP_W = AVG_SHIFT;

    // Battery divider gain in Q8 and millivolt scaling
    localparam int BATT_MULT_Q8 = 512;
    localparam int GAIN_W       = 15;
    localparam logic [GAIN_W-1:0] MV_GAIN = GAIN_W'(8 * BATT_MULT_Q8);
    localparam int SCALED_W     = 27;

    // Divide by 4095 with half-up rounding: exact reciprocal multiply
    localparam int FULL_SCALE_W = 12;
    localparam logic [SCALED_W-1:0] HALF_FULL_SCALE = SCALED_W'(2047);
    localparam int DIV_SHIFT    = SCALED_W + FULL_SCALE_W;
    localparam int DIV_RECIP_W  = 28;
    localparam logic [DIV_RECIP_W-1:0] DIV_RECIP =
        DIV_RECIP_W'(((64'd1 << DIV_SHIFT) + 64'd4094) / 64'd4095);

    // Temperature: avg*2048 + 2047, then divide by 4095, minus 50.0 degrees
    localparam int TEMP_X_W = SAMPLE_W + 11;
    localparam logic [TEMP_W-1:0] TEMP_OFFSET = TEMP_W'(500);

    // Front to back queue
    localparam int QUEUE_DEPTH = 4;

    // Scan operations
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_PRIME  = 1'b1;

    // Register map
    localparam logic [CFG_IDX_W-1:0] REG_BATT_CRIT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BATT_EMPTY    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BATT_QUARTER  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BATT_HALF     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BATT_3QUARTER = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STAT1_THR     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STAT2_THR     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BUTTON_THR    = 3'd7;

    // Register reset values
    localparam logic [THR_MV_W-1:0]  RST_BATT_CRIT     = 15'd3300;
    localparam logic [THR_MV_W-1:0]  RST_BATT_EMPTY    = 15'd3500;
    localparam logic [THR_MV_W-1:0]  RST_BATT_QUARTER  = 15'd3700;
    localparam logic [THR_MV_W-1:0]  RST_BATT_HALF     = 15'd3800;
    localparam logic [THR_MV_W-1:0]  RST_BATT_3QUARTER = 15'd3950;
    localparam logic [THR_CNT_W-1:0] RST_CNT_THR       = 13'd2048;

    // Battery levels
    localparam logic [LEVEL_W-1:0] LVL_CRITICAL = 3'd0;
    localparam logic [LEVEL_W-1:0] LVL_EMPTY    = 3'd1;
    localparam logic [LEVEL_W-1:0] LVL_QUARTER  = 3'd2;
    localparam logic [LEVEL_W-1:0] LVL_HALF     = 3'd3;
    localparam logic [LEVEL_W-1:0] LVL_3QUARTER = 3'd4;
    localparam logic [LEVEL_W-1:0] LVL_FULL     = 3'd5;

    // Charge states
    localparam logic [CHARGE_W-1:0] CHG_OFF   = 2'd0;
    localparam logic [CHARGE_W-1:0] CHG_ON    = 2'd1;
    localparam logic [CHARGE_W-1:0] CHG_FAULT = 2'd2;

    typedef struct packed {
        logic                op;
        logic [SAMPLE_W-1:0] button_sample;
        logic [SAMPLE_W-1:0] stat2_sample;
        logic [SAMPLE_W-1:0] batt_sample;
        logic [SAMPLE_W-1:0] stat1_sample;
        logic [SAMPLE_W-1:0] temp_sample;
    } bttm_in_t;

    typedef struct packed {
        logic [MV_W-1:0]          batt_millivolts;
        logic [LEVEL_W-1:0]       batt_level;
        logic [CHARGE_W-1:0]      chg_status;
        logic signed [TEMP_W-1:0] temp_tenths_c;
        logic                     button_pressed;
    } bttm_out_t;

    // Ring sums after one scan, handed from front to back
    typedef struct packed {
        logic [SUM_W-1:0] batt_sum;
        logic [SUM_W-1:0] temp_sum;
        logic [SUM_W-1:0] stat1_sum;
        logic [SUM_W-1:0] stat2_sum;
        logic             button_pressed;
    } bttm_front_t;

    typedef struct packed {
        logic [4:0][THR_MV_W-1:0] batt_thr_mv;
        logic [THR_CNT_W-1:0]     stat1_thr;
        logic [THR_CNT_W-1:0]     stat2_thr;
        logic [THR_CNT_W-1:0]     button_thr;
    } bttm_cfg_t;

endpackage

// File: src/battery_temp_button_monitor.sv
// Top level of the battery, temperature and button monitor.
// Holds the register file and joins front end, queue and back end. Depends on bttm_pkg.

// Each scan request carries five 12-bit converter channels. Battery, temperature
// and both charger-status channels go into rings (depths set by the parameters),
// each kept with a running sum; a prime scan fills every ring with its samples and
// marks the button as previously pressed. Every scan gives exactly one result:
// battery millivolts and six-way level, charge state (off / on / fault), temperature
// in tenths of a degree and a debounced button bit. One scan is taken every clock
// cycle while scan_stall is low. The front end updates the rings in the cycle it
// accepts a scan (the ring RAMs do one write and one read-ahead a cycle); a four-entry
// queue then feeds a three-stage back end. A result leaves the queue into stage one,
// then passes stages two and three; result_valid is the stage-three valid bit.
// scan_stall rises only when the queue is full. Registers are written through
// cfg_valid/cfg_ready, which is always ready, and should be written only while no
// scan is in flight.
module battery_temp_button_monitor #(
    parameter int BATT_SAMPLES = bttm_pkg::BATT_SAMPLES_DEF,
    parameter int TEMP_SAMPLES = bttm_pkg::TEMP_SAMPLES_DEF,
    parameter int STAT_SAMPLES = bttm_pkg::STAT_SAMPLES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // scan requests
    input  logic                            scan_valid,
    output logic                            scan_stall,
    input  bttm_pkg::bttm_in_t              scan_data,
    // result requests
    output logic                            result_valid,
    input  logic                            result_stall,
    output bttm_pkg::bttm_out_t             result_data,
    // register writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bttm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bttm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bttm_pkg::*;

    bttm_cfg_t   cfg_reg, cfg_next;
    logic        push, pop;
    logic        queue_full, queue_not_empty;
    bttm_front_t push_data, head;

    assign cfg_ready = 1'b1;

    // register file: 15-bit millivolt thresholds, 13-bit count thresholds
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_BATT_CRIT:     cfg_next.batt_thr_mv[0] = cfg_data;
                REG_BATT_EMPTY:    cfg_next.batt_thr_mv[1] = cfg_data;
                REG_BATT_QUARTER:  cfg_next.batt_thr_mv[2] = cfg_data;
                REG_BATT_HALF:     cfg_next.batt_thr_mv[3] = cfg_data;
                REG_BATT_3QUARTER: cfg_next.batt_thr_mv[4] = cfg_data;
                REG_STAT1_THR:     cfg_next.stat1_thr      = cfg_data[THR_CNT_W-1:0];
                REG_STAT2_THR:     cfg_next.stat2_thr      = cfg_data[THR_CNT_W-1:0];
                REG_BUTTON_THR:    cfg_next.button_thr     = cfg_data[THR_CNT_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.batt_thr_mv[0] <= RST_BATT_CRIT;
            cfg_reg.batt_thr_mv[1] <= RST_BATT_EMPTY;
            cfg_reg.batt_thr_mv[2] <= RST_BATT_QUARTER;
            cfg_reg.batt_thr_mv[3] <= RST_BATT_HALF;
            cfg_reg.batt_thr_mv[4] <= RST_BATT_3QUARTER;
            cfg_reg.stat1_thr      <= RST_CNT_THR;
            cfg_reg.stat2_thr      <= RST_CNT_THR;
            cfg_reg.button_thr     <= RST_CNT_THR;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front end: ring updates and button history
    bttm_front #(
        .BATT_SAMPLES (BATT_SAMPLES),
        .TEMP_SAMPLES (TEMP_SAMPLES),
        .STAT_SAMPLES (STAT_SAMPLES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .scan_valid (scan_valid),
        .scan_stall (scan_stall),
        .scan_data  (scan_data),
        .button_thr (cfg_reg.button_thr),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    // decouples ring updates from output back-pressure
    bttm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .head      (head)
    );

    // back end: averaging, scaling and decode
    bttm_back #(
        .BATT_SAMPLES (BATT_SAMPLES),
        .TEMP_SAMPLES (TEMP_SAMPLES),
        .STAT_SAMPLES (STAT_SAMPLES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head_valid   (queue_not_empty),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

endmodule

// File: src/bttm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bttm_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: src/bttm_ring.sv
// One sample ring with a running sum; entries not written since the last prime
// read as the prime value. Depends on bttm_pkg and bttm_ram.
module bttm_ring #(
    parameter int DEPTH = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           prime,
    input  logic [bttm_pkg::SAMPLE_W-1:0]  sample,
    output logic [bttm_pkg::SUM_W-1:0]     sum_next
);
    import bttm_pkg::*;

    localparam int SLOT_W = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);

    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [SAMPLE_W-1:0] prime_val_reg, prime_val_next;
    logic [SUM_W-1:0]    sum_reg;
    logic [SAMPLE_W-1:0] ram_rd;
    logic [SAMPLE_W-1:0] oldest;
    logic                wr_en;

    // entry at slot holds the prime value until overwritten since the prime
    assign oldest = (fill_reg > FILL_W'(slot_reg)) ? ram_rd : prime_val_reg;
    assign wr_en  = en && !prime;

    always_comb
    begin
        slot_next      = slot_reg;
        fill_next      = fill_reg;
        prime_val_next = prime_val_reg;
        sum_next       = sum_reg;
        if (en)
        begin
            if (prime)
            begin
                slot_next      = '0;
                fill_next      = '0;
                prime_val_next = sample;
                sum_next       = SUM_W'(SUM_W'(sample) * SUM_W'(DEPTH));
            end
            else
            begin
                slot_next = (slot_reg == SLOT_W'(DEPTH - 1)) ? '0 : slot_reg + SLOT_W'(1);
                if (fill_reg != FILL_W'(DEPTH))
                begin
                    fill_next = fill_reg + FILL_W'(1);
                end
                sum_next = sum_reg + SUM_W'(sample) - SUM_W'(oldest);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            fill_reg      <= '0;
            prime_val_reg <= '0;
            sum_reg       <= '0;
        end
        else
        begin
            slot_reg      <= slot_next;
            fill_reg      <= fill_next;
            prime_val_reg <= prime_val_next;
            sum_reg       <= sum_next;
        end
    end

    // read ahead at the next slot so the oldest entry is ready on the next scan
    bttm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (slot_reg),
        .wr_data (sample),
        .rd_addr (slot_next),
        .rd_data (ram_rd)
    );

    // writes since a prime run from slot zero, so the fill count tracks the slot
    a_fill_tracks_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == FILL_W'(DEPTH)) || (fill_reg == FILL_W'(slot_reg)))
        else $error("ring fill count out of step with slot");

endmodule

// File: src/bttm_front.sv
// Front end: accepts scans, updates the four rings and the button history,
// and queues the new ring sums. Depends on bttm_pkg and bttm_ring.
module bttm_front #(
    parameter int BATT_SAMPLES = bttm_pkg::BATT_SAMPLES_DEF,
    parameter int TEMP_SAMPLES = bttm_pkg::TEMP_SAMPLES_DEF,
    parameter int STAT_SAMPLES = bttm_pkg::STAT_SAMPLES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           scan_valid,
    output logic                           scan_stall,
    input  bttm_pkg::bttm_in_t             scan_data,
    input  logic [bttm_pkg::THR_CNT_W-1:0] button_thr,
    input  logic                           queue_full,
    output logic                           push,
    output bttm_pkg::bttm_front_t          push_data
);
    import bttm_pkg::*;

    logic accept;
    logic prime;
    logic button_high;
    logic button_prev_reg, button_prev_next;

    assign scan_stall = queue_full;
    assign accept     = scan_valid && !queue_full;
    assign prime      = (scan_data.op == OP_PRIME);
    assign push       = accept;

    assign button_high = ({1'b0, scan_data.button_sample} >= button_thr);
    assign push_data.button_pressed = button_high && (prime || button_prev_reg);
    assign button_prev_next = accept ? button_high : button_prev_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            button_prev_reg <= 1'b1;
        end
        else
        begin
            button_prev_reg <= button_prev_next;
        end
    end

    bttm_ring #(.DEPTH(BATT_SAMPLES)) u_batt_ring (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (accept),
        .prime    (prime),
        .sample   (scan_data.batt_sample),
        .sum_next (push_data.batt_sum)
    );

    bttm_ring #(.DEPTH(TEMP_SAMPLES)) u_temp_ring (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (accept),
        .prime    (prime),
        .sample   (scan_data.temp_sample),
        .sum_next (push_data.temp_sum)
    );

    bttm_ring #(.DEPTH(STAT_SAMPLES)) u_stat1_ring (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (accept),
        .prime    (prime),
        .sample   (scan_data.stat1_sample),
        .sum_next (push_data.stat1_sum)
    );

    bttm_ring #(.DEPTH(STAT_SAMPLES)) u_stat2_ring (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (accept),
        .prime    (prime),
        .sample   (scan_data.stat2_sample),
        .sum_next (push_data.stat2_sum)
    );

endmodule

// File: src/bttm_queue.sv
// Short queue of ring sums between the front and back ends.
// Depends on bttm_pkg.
module bttm_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  bttm_pkg::bttm_front_t push_data,
    input  logic                  pop,
    output logic                  full,
    output logic                  not_empty,
    output bttm_pkg::bttm_front_t head
);
    import bttm_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    bttm_front_t       entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue overrun");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue underrun");

endmodule

// File: src/bttm_back.sv
// Back end: three-stage pipeline from ring sums to the result request.
// Averages, millivolt and temperature scaling, level and charge decode. Depends on bttm_pkg.
module bttm_back #(
    parameter int BATT_SAMPLES = bttm_pkg::BATT_SAMPLES_DEF,
    parameter int TEMP_SAMPLES = bttm_pkg::TEMP_SAMPLES_DEF,
    parameter int STAT_SAMPLES = bttm_pkg::STAT_SAMPLES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bttm_pkg::bttm_cfg_t   cfg,
    input  logic                  head_valid,
    input  bttm_pkg::bttm_front_t head,
    output logic                  pop,
    output logic                  result_valid,
    input  logic                  result_stall,
    output bttm_pkg::bttm_out_t   result_data
);
    import bttm_pkg::*;

    localparam int PROD_W     = SUM_W + AVG_RECIP_W;
    localparam int MV_PROD_W  = SCALED_W + DIV_RECIP_W;
    localparam int TMP_PROD_W = TEMP_X_W + DIV_RECIP_W;
    localparam int THR_X_W    = THR_MV_W + FULL_SCALE_W;

    // rounding bias: sum + n - n/2 makes the floor divide round as required
    localparam logic [SUM_W-1:0] BATT_BIAS = SUM_W'(BATT_SAMPLES - BATT_SAMPLES / 2);
    localparam logic [SUM_W-1:0] TEMP_BIAS = SUM_W'(TEMP_SAMPLES - TEMP_SAMPLES / 2);
    localparam logic [SUM_W-1:0] STAT_BIAS = SUM_W'(STAT_SAMPLES - STAT_SAMPLES / 2);
    localparam logic [AVG_RECIP_W-1:0] BATT_RECIP =
        AVG_RECIP_W'(((64'd1 << AVG_SHIFT) + BATT_SAMPLES - 1) / BATT_SAMPLES);
    localparam logic [AVG_RECIP_W-1:0] TEMP_RECIP =
        AVG_RECIP_W'(((64'd1 << AVG_SHIFT) + TEMP_SAMPLES - 1) / TEMP_SAMPLES);
    localparam logic [AVG_RECIP_W-1:0] STAT_RECIP =
        AVG_RECIP_W'(((64'd1 << AVG_SHIFT) + STAT_SAMPLES - 1) / STAT_SAMPLES);

    function automatic logic [SAMPLE_W-1:0] avg_of(
        input logic [SUM_W-1:0]       sum,
        input logic [SUM_W-1:0]       bias,
        input logic [AVG_RECIP_W-1:0] recip
    );
        logic [PROD_W-1:0] prod;
        prod   = PROD_W'(sum + bias) * PROD_W'(recip);
        avg_of = prod[AVG_SHIFT +: SAMPLE_W];
    endfunction

    logic advance;

    // stage 1: averages
    logic                v1_reg;
    logic [SAMPLE_W-1:0] batt_avg_reg, temp_avg_reg, stat1_avg_reg, stat2_avg_reg;
    logic                btn1_reg;

    // stage 2: scaled battery, temperature numerator, charge state
    logic                v2_reg;
    logic [SCALED_W-1:0] scaled_reg;
    logic [TEMP_X_W-1:0] temp_x_reg;
    logic [CHARGE_W-1:0] charge_reg;
    logic                btn2_reg;
    logic                stat1_high, stat2_high;
    logic [CHARGE_W-1:0] charge_next;

    // stage 3: output register
    logic                v3_reg;
    bttm_out_t           result_reg, result_next;
    logic [MV_PROD_W-1:0]  mv_prod;
    logic [TMP_PROD_W-1:0] temp_prod;
    logic [SAMPLE_W-1:0]   temp_q;
    logic [SCALED_W-1:0]   thr_scaled [5];

    assign advance      = !v3_reg || !result_stall;
    assign pop          = advance && head_valid;
    assign result_valid = v3_reg;
    assign result_data  = result_reg;

    assign stat1_high = ({1'b0, stat1_avg_reg} >= cfg.stat1_thr);
    assign stat2_high = ({1'b0, stat2_avg_reg} >= cfg.stat2_thr);

    always_comb
    begin
        if (stat1_high)
        begin
            charge_next = CHG_OFF;
        end
        else if (stat2_high)
        begin
            charge_next = CHG_ON;
        end
        else
        begin
            charge_next = CHG_FAULT;
        end
    end

    // thresholds in the same scale as avg*8*gain: thr * 4095
    always_comb
    begin
        for (int i = 0; i < 5; i++)
        begin
            thr_scaled[i] = SCALED_W'({cfg.batt_thr_mv[i], {FULL_SCALE_W{1'b0}}})
                          - SCALED_W'(cfg.batt_thr_mv[i]);
        end
    end

    assign mv_prod   = MV_PROD_W'(scaled_reg + HALF_FULL_SCALE) * MV_PROD_W'(DIV_RECIP);
    assign temp_prod = TMP_PROD_W'(temp_x_reg) * TMP_PROD_W'(DIV_RECIP);
    assign temp_q    = temp_prod[DIV_SHIFT +: SAMPLE_W];

    always_comb
    begin
        result_next.batt_millivolts = mv_prod[DIV_SHIFT +: MV_W];
        result_next.chg_status      = charge_reg;
        result_next.temp_tenths_c   = signed'(temp_q - TEMP_OFFSET);
        result_next.button_pressed  = btn2_reg;
        // first match from critical upward, whatever the threshold order
        if (scaled_reg <= thr_scaled[0])
        begin
            result_next.batt_level = LVL_CRITICAL;
        end
        else if (scaled_reg <= thr_scaled[1])
        begin
            result_next.batt_level = LVL_EMPTY;
        end
        else if (scaled_reg <= thr_scaled[2])
        begin
            result_next.batt_level = LVL_QUARTER;
        end
        else if (scaled_reg <= thr_scaled[3])
        begin
            result_next.batt_level = LVL_HALF;
        end
        else if (scaled_reg <= thr_scaled[4])
        begin
            result_next.batt_level = LVL_3QUARTER;
        end
        else
        begin
            result_next.batt_level = LVL_FULL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= head_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            batt_avg_reg  <= avg_of(head.batt_sum, BATT_BIAS, BATT_RECIP);
            temp_avg_reg  <= avg_of(head.temp_sum, TEMP_BIAS, TEMP_RECIP);
            stat1_avg_reg <= avg_of(head.stat1_sum, STAT_BIAS, STAT_RECIP);
            stat2_avg_reg <= avg_of(head.stat2_sum, STAT_BIAS, STAT_RECIP);
            btn1_reg      <= head.button_pressed;

            scaled_reg <= SCALED_W'(SCALED_W'(batt_avg_reg) * SCALED_W'(MV_GAIN));
            temp_x_reg <= {temp_avg_reg, 11'h7FF};
            charge_reg <= charge_next;
            btn2_reg   <= btn1_reg;

            result_reg <= result_next;
        end
    end

    a_pop_fills_stage1: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> v1_reg)
        else $error("popped request lost before stage one");

    a_stage_shift: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (v3_reg == $past(v2_reg)) && (v2_reg == $past(v1_reg)))
        else $error("pipeline valid bits did not shift together");

endmodule

// File: tb/bttm_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the battery, temperature and button monitor: keeps its own copy of
// the averaging windows and thresholds, predicts every reading and checks each result.
// Depends on bttm_pkg.
module bttm_checker #(
    parameter int BATT_N = bttm_pkg::BATT_SAMPLES_DEF,
    parameter int TEMP_N = bttm_pkg::TEMP_SAMPLES_DEF,
    parameter int STAT_N = bttm_pkg::STAT_SAMPLES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            scan_valid,
    input  logic                            scan_stall,
    input  bttm_pkg::bttm_in_t              scan_data,
    input  logic                            result_valid,
    input  logic                            result_stall,
    input  bttm_pkg::bttm_out_t             result_data,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [bttm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bttm_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              mismatches,
    output int                              readings_owed
);
    import bttm_pkg::*;

    localparam longint unsigned FULL_SCALE   = 4095;
    localparam longint unsigned HALF_SCALE   = 2047;
    localparam longint unsigned TEMP_SPAN    = 2048;
    localparam longint unsigned MV_NUM       = 8 * BATT_MULT_Q8;
    localparam int              TEMP_ZERO    = 500;

    logic [SAMPLE_W-1:0]  batt_win  [BATT_N];
    logic [SAMPLE_W-1:0]  temp_win  [TEMP_N];
    logic [SAMPLE_W-1:0]  stat1_win [STAT_N];
    logic [SAMPLE_W-1:0]  stat2_win [STAT_N];
    int unsigned          batt_pos;
    int unsigned          temp_pos;
    int unsigned          stat_pos;
    logic                 btn_was_high;
    logic [THR_MV_W-1:0]  level_thr [5];
    logic [THR_CNT_W-1:0] stat1_thr;
    logic [THR_CNT_W-1:0] stat2_thr;
    logic [THR_CNT_W-1:0] btn_thr;
    bttm_out_t            owed_q [$];
    int                   errs;

    // mean of a window, rounded up when the remainder reaches half the depth
    function automatic int unsigned rounded_mean(input int unsigned total, input int unsigned n);
        int unsigned q;
        q = total / n;
        if ((total % n) >= (n / 2))
            q = q + 1;
        return q;
    endfunction

    function automatic bttm_out_t predict_reading(input bttm_in_t s);
        int              i;
        int unsigned     batt_total;
        int unsigned     temp_total;
        int unsigned     s1_total;
        int unsigned     s2_total;
        int unsigned     temp_mean;
        longint unsigned scaled;
        logic            s1_high;
        logic            s2_high;
        logic            now_high;
        bttm_out_t       r;
        if (s.op == OP_PRIME)
        begin
            for (i = 0; i < BATT_N; i++)
                batt_win[i] = s.batt_sample;
            for (i = 0; i < TEMP_N; i++)
                temp_win[i] = s.temp_sample;
            for (i = 0; i < STAT_N; i++)
            begin
                stat1_win[i] = s.stat1_sample;
                stat2_win[i] = s.stat2_sample;
            end
            batt_pos = 0;
            temp_pos = 0;
            stat_pos = 0;
            btn_was_high = 1'b1;
        end
        else
        begin
            batt_win[batt_pos] = s.batt_sample;
            batt_pos = (batt_pos + 1 == BATT_N) ? 0 : batt_pos + 1;
            temp_win[temp_pos] = s.temp_sample;
            temp_pos = (temp_pos + 1 == TEMP_N) ? 0 : temp_pos + 1;
            stat1_win[stat_pos] = s.stat1_sample;
            stat2_win[stat_pos] = s.stat2_sample;
            stat_pos = (stat_pos + 1 == STAT_N) ? 0 : stat_pos + 1;
        end

        batt_total = 0;
        temp_total = 0;
        s1_total = 0;
        s2_total = 0;
        for (i = 0; i < BATT_N; i++)
            batt_total += batt_win[i];
        for (i = 0; i < TEMP_N; i++)
            temp_total += temp_win[i];
        for (i = 0; i < STAT_N; i++)
        begin
            s1_total += stat1_win[i];
            s2_total += stat2_win[i];
        end

        // levels test the unrounded voltage against each threshold, lowest first
        scaled = 64'(rounded_mean(batt_total, BATT_N)) * MV_NUM;
        r.batt_millivolts = MV_W'((scaled + HALF_SCALE) / FULL_SCALE);
        if (scaled <= level_thr[LVL_CRITICAL] * FULL_SCALE)
            r.batt_level = LVL_CRITICAL;
        else if (scaled <= level_thr[LVL_EMPTY] * FULL_SCALE)
            r.batt_level = LVL_EMPTY;
        else if (scaled <= level_thr[LVL_QUARTER] * FULL_SCALE)
            r.batt_level = LVL_QUARTER;
        else if (scaled <= level_thr[LVL_HALF] * FULL_SCALE)
            r.batt_level = LVL_HALF;
        else if (scaled <= level_thr[LVL_3QUARTER] * FULL_SCALE)
            r.batt_level = LVL_3QUARTER;
        else
            r.batt_level = LVL_FULL;

        s1_high = rounded_mean(s1_total, STAT_N) >= stat1_thr;
        s2_high = rounded_mean(s2_total, STAT_N) >= stat2_thr;
        if (s1_high)
            r.chg_status = CHG_OFF;
        else if (s2_high)
            r.chg_status = CHG_ON;
        else
            r.chg_status = CHG_FAULT;

        temp_mean = rounded_mean(temp_total, TEMP_N);
        r.temp_tenths_c = TEMP_W'(int'((64'(temp_mean) * TEMP_SPAN + HALF_SCALE) / FULL_SCALE)
                                  - TEMP_ZERO);

        now_high = {1'b0, s.button_sample} >= btn_thr;
        r.button_pressed = now_high && btn_was_high;
        btn_was_high = now_high;
        return r;
    endfunction

    task automatic flag(input string field, input int want, input int got);
        $error("%s: expected %0d, got %0d", field, want, got);
        errs++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        int        i;
        bttm_out_t want;
        if (!rst_n)
        begin
            for (i = 0; i < BATT_N; i++)
                batt_win[i] = '0;
            for (i = 0; i < TEMP_N; i++)
                temp_win[i] = '0;
            for (i = 0; i < STAT_N; i++)
            begin
                stat1_win[i] = '0;
                stat2_win[i] = '0;
            end
            batt_pos = 0;
            temp_pos = 0;
            stat_pos = 0;
            btn_was_high = 1'b1;
            level_thr[LVL_CRITICAL] = RST_BATT_CRIT;
            level_thr[LVL_EMPTY] = RST_BATT_EMPTY;
            level_thr[LVL_QUARTER] = RST_BATT_QUARTER;
            level_thr[LVL_HALF] = RST_BATT_HALF;
            level_thr[LVL_3QUARTER] = RST_BATT_3QUARTER;
            stat1_thr = RST_CNT_THR;
            stat2_thr = RST_CNT_THR;
            btn_thr = RST_CNT_THR;
            owed_q.delete();
            errs = 0;
            mismatches <= 0;
            readings_owed <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_BATT_CRIT:     level_thr[LVL_CRITICAL] = cfg_data;
                    REG_BATT_EMPTY:    level_thr[LVL_EMPTY] = cfg_data;
                    REG_BATT_QUARTER:  level_thr[LVL_QUARTER] = cfg_data;
                    REG_BATT_HALF:     level_thr[LVL_HALF] = cfg_data;
                    REG_BATT_3QUARTER: level_thr[LVL_3QUARTER] = cfg_data;
                    REG_STAT1_THR:     stat1_thr = cfg_data[THR_CNT_W-1:0];
                    REG_STAT2_THR:     stat2_thr = cfg_data[THR_CNT_W-1:0];
                    REG_BUTTON_THR:    btn_thr = cfg_data[THR_CNT_W-1:0];
                    default:           ;
                endcase
            end

            if (result_valid && !result_stall)
            begin
                if (owed_q.size() == 0)
                begin
                    $error("result request with no scan outstanding");
                    errs++;
                end
                else
                begin
                    want = owed_q.pop_front();
                    if (result_data.batt_millivolts !== want.batt_millivolts)
                        flag("batt_millivolts", int'(want.batt_millivolts),
                             int'(result_data.batt_millivolts));
                    if (result_data.batt_level !== want.batt_level)
                        flag("batt_level", int'(want.batt_level),
                             int'(result_data.batt_level));
                    if (result_data.chg_status !== want.chg_status)
                        flag("chg_status", int'(want.chg_status),
                             int'(result_data.chg_status));
                    if (result_data.temp_tenths_c !== want.temp_tenths_c)
                        flag("temp_tenths_c", int'($signed(want.temp_tenths_c)),
                             int'($signed(result_data.temp_tenths_c)));
                    if (result_data.button_pressed !== want.button_pressed)
                        flag("button_pressed", int'(want.button_pressed),
                             int'(result_data.button_pressed));
                end
            end

            if (scan_valid && !scan_stall)
                owed_q.push_back(predict_reading(scan_data));

            mismatches <= errs;
            readings_owed <= owed_q.size();
        end
    end

endmodule

// File: tb/battery_temp_button_monitor_tb.sv
`timescale 1ns / 100ps
// Top of the monitor testbench: clock, reset, scan and register stimulus, result-side
// stalls and the verdict. Depends on bttm_pkg, the block and bttm_checker.
module battery_temp_button_monitor_tb;
    import bttm_pkg::*;

    localparam int SAMPLE_MAX    = (1 << SAMPLE_W) - 1;
    localparam int NUM_REGS      = 8;
    localparam int PHASES        = 8;
    localparam int HOLD_CYCLES   = 64;     // long result-side hold-off, fills the queue
    localparam int SETTLE_CYCLES = 12;     // pipeline plus queue, with margin

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  scan_valid = 1'b0;
    logic                  scan_stall;
    bttm_in_t              scan_data = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    bttm_out_t             result_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    mismatches;
    int                    readings_owed;

    // What has been written to the registers: steers samples towards the live thresholds
    logic [CFG_DATA_W-1:0] reg_val [NUM_REGS];
    logic [SAMPLE_W-1:0]   last_button = '0;
    int                    batt_target = 0;
    int                    send_calm = 0;

    battery_temp_button_monitor uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .scan_valid   (scan_valid),
        .scan_stall   (scan_stall),
        .scan_data    (scan_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    bttm_checker scoreboard (
        .clk           (clk),
        .rst_n         (rst_n),
        .scan_valid    (scan_valid),
        .scan_stall    (scan_stall),
        .scan_data     (scan_data),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result_data   (result_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .readings_owed (readings_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog. Slowest honest run: ~1450 scans, each behind the longest send gap and
    // the longest result stall plus the pipeline, well inside the timeout below.
    initial
    begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    // Idle length: mostly none or short, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    // A converter reading that lands close to a threshold about half the time, so the
    // window means straddle it; otherwise a rail or anything at all.
    function automatic logic [SAMPLE_W-1:0] near_count(input int thr);
        int r;
        int v;
        r = $urandom_range(0, 9);
        if (r < 5)
            v = thr + int'($urandom_range(0, 16)) - 8;
        else if (r < 6)
            v = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
        else
            v = $urandom_range(0, SAMPLE_MAX);
        if (v < 0)
            v = 0;
        if (v > SAMPLE_MAX)
            v = SAMPLE_MAX;
        return SAMPLE_W'(v);
    endfunction

    function automatic bttm_in_t make_scan(input logic op, input int bat, input int tmp,
                                           input int s1, input int s2, input int btn);
        bttm_in_t s;
        s.op = op;
        s.batt_sample = SAMPLE_W'(bat);
        s.temp_sample = SAMPLE_W'(tmp);
        s.stat1_sample = SAMPLE_W'(s1);
        s.stat2_sample = SAMPLE_W'(s2);
        s.button_sample = SAMPLE_W'(btn);
        return s;
    endfunction

    function automatic bttm_in_t random_scan();
        bttm_in_t s;
        s.op = ($urandom_range(0, 24) == 0) ? OP_PRIME : OP_UPDATE;
        // battery hovers round one level threshold (register 0..4) for a while
        if ($urandom_range(0, 9) == 0)
            batt_target = $urandom_range(0, 4);
        s.batt_sample = near_count(int'(reg_val[batt_target]));
        s.stat1_sample = near_count(int'(reg_val[REG_STAT1_THR][THR_CNT_W-1:0]));
        s.stat2_sample = near_count(int'(reg_val[REG_STAT2_THR][THR_CNT_W-1:0]));
        if ($urandom_range(0, 9) == 0)
            s.temp_sample = $urandom_range(0, 1) ? SAMPLE_W'(SAMPLE_MAX) : '0;
        else
            s.temp_sample = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
        // repeats give runs of held or released button
        if ($urandom_range(0, 1))
            s.button_sample = last_button;
        else
            s.button_sample = near_count(int'(reg_val[REG_BUTTON_THR][THR_CNT_W-1:0]));
        last_button = s.button_sample;
        return s;
    endfunction

    // Offer one scan request and hold it until taken, then maybe leave a gap.
    // valid is only dropped when a gap follows, so back-to-back requests keep it high.
    task automatic send_scan(input bttm_in_t s);
        int gap;
        scan_valid <= 1'b1;
        scan_data <= s;
        @(posedge clk);
        while (scan_stall)
            @(posedge clk);
        if (send_calm > 0)
        begin
            send_calm--;
            gap = 0;
        end
        else
        begin
            gap = idle_len();
            if ($urandom_range(0, 49) == 0)
                send_calm = $urandom_range(20, 80);
        end
        if (gap > 0)
        begin
            scan_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop offering and wait until every reading owed has come back
    task automatic wait_drained();
        scan_valid <= 1'b0;
        @(posedge clk);
        while (readings_owed != 0)
            @(posedge clk);
    endtask

    // Write all registers from reg_val, back to back, then release the channel
    task automatic program_regs();
        int i;
        for (i = 0; i < NUM_REGS; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data <= reg_val[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        int phase;
        int n;
        int i;
        int items;
        int base;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed scans under the reset thresholds (2048 counts, 3300..3950 mV).
        // Button is remembered as pressed out of reset: a high first scan reads pressed.
        send_scan(make_scan(OP_UPDATE, 0, 0, 0, 0, SAMPLE_MAX));
        // just below, then at, the button threshold: needs two high scans in a row
        send_scan(make_scan(OP_UPDATE, 0, 0, 0, 0, 2047));
        send_scan(make_scan(OP_UPDATE, 0, 0, 0, 0, 2048));
        send_scan(make_scan(OP_UPDATE, 0, 0, 0, 0, 2048));
        // mean rounding: a window sum of 3 stays at 0, a sum of 4 rounds up to 1
        send_scan(make_scan(OP_PRIME, 0, 0, 0, 0, 0));
        send_scan(make_scan(OP_UPDATE, 3, 3, 3, 3, 0));
        send_scan(make_scan(OP_UPDATE, 1, 1, 1, 1, 0));
        // prime forces the previous button to pressed even after a released scan
        send_scan(make_scan(OP_PRIME, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX,
                            SAMPLE_MAX));
        send_scan(make_scan(OP_UPDATE, 0, 0, 0, 0, 0));
        send_scan(make_scan(OP_PRIME, 0, 0, 0, 0, SAMPLE_MAX));
        // each battery level, edges of critical, and all three charge states
        send_scan(make_scan(OP_PRIME, 3299, 1000, 2048, 0, 0));
        send_scan(make_scan(OP_PRIME, 3300, 2000, 2047, 2048, 0));
        send_scan(make_scan(OP_PRIME, 3600, 3000, 2047, 2047, 0));
        send_scan(make_scan(OP_PRIME, 3750, 4000, SAMPLE_MAX, SAMPLE_MAX, 0));
        send_scan(make_scan(OP_PRIME, 3900, 2048, 0, SAMPLE_MAX, 0));
        send_scan(make_scan(OP_PRIME, 3950, 2047, 0, 0, 0));
        // alternating bit patterns through the window
        send_scan(make_scan(OP_UPDATE, 'hAAA, 'hAAA, 'hAAA, 'hAAA, 'hAAA));
        send_scan(make_scan(OP_UPDATE, 'h555, 'h555, 'h555, 'h555, 'h555));
        send_scan(make_scan(OP_UPDATE, SAMPLE_MAX, 0, SAMPLE_MAX, 0, SAMPLE_MAX));

        // Random phases, each under a fresh register setting written while idle
        for (phase = 0; phase < PHASES; phase++)
        begin
            wait_drained();
            case (phase)
                0, 7:
                begin
                    reg_val[REG_BATT_CRIT] = RST_BATT_CRIT;
                    reg_val[REG_BATT_EMPTY] = RST_BATT_EMPTY;
                    reg_val[REG_BATT_QUARTER] = RST_BATT_QUARTER;
                    reg_val[REG_BATT_HALF] = RST_BATT_HALF;
                    reg_val[REG_BATT_3QUARTER] = RST_BATT_3QUARTER;
                    reg_val[REG_STAT1_THR] = CFG_DATA_W'(RST_CNT_THR);
                    reg_val[REG_STAT2_THR] = CFG_DATA_W'(RST_CNT_THR);
                    reg_val[REG_BUTTON_THR] = CFG_DATA_W'(RST_CNT_THR);
                    items = (phase == 0) ? 250 : 240;
                end
                1:
                begin
                    // everything zero: button always high, status one always high
                    for (i = 0; i < NUM_REGS; i++)
                        reg_val[i] = '0;
                    items = 120;
                end
                2:
                begin
                    // all ones: count thresholds keep their low 13 bits only
                    for (i = 0; i < NUM_REGS; i++)
                        reg_val[i] = '1;
                    items = 120;
                end
                6:
                begin
                    // plausible ascending battery thresholds, counts round mid-scale
                    base = $urandom_range(2900, 3300);
                    for (i = int'(REG_BATT_CRIT); i <= int'(REG_BATT_3QUARTER); i++)
                    begin
                        reg_val[i] = CFG_DATA_W'(base);
                        base += $urandom_range(0, 250);
                    end
                    for (i = int'(REG_STAT1_THR); i <= int'(REG_BUTTON_THR); i++)
                        reg_val[i] = CFG_DATA_W'($urandom_range(1500, 2600));
                    items = 250;
                end
                default:
                begin
                    // thresholds in no particular order; now and then any 15-bit value
                    for (i = 0; i < NUM_REGS; i++)
                    begin
                        if ($urandom_range(0, 7) == 0)
                            reg_val[i] = CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1));
                        else
                            reg_val[i] = CFG_DATA_W'($urandom_range(0, 4300));
                    end
                    items = 150;
                end
            endcase
            program_regs();
            for (n = 0; n < items; n++)
                send_scan(random_scan());
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Result side. Random stalls with calm stretches; twice, once scans are on offer,
    // a long hold-off so the queue fills and the block has to stall its scan input.
    initial
    begin : result_side
        int cycles_seen;
        int next_hold_at;
        int holds_left;
        int stall_len;
        int calm;
        cycles_seen = 0;
        next_hold_at = 1000;
        holds_left = 2;
        calm = 0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (holds_left > 0 && cycles_seen >= next_hold_at && scan_valid)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                cycles_seen += HOLD_CYCLES;
                holds_left--;
                next_hold_at = cycles_seen + 2000;
            end
            else
            begin
                if (calm > 0)
                begin
                    calm--;
                    stall_len = 0;
                end
                else
                begin
                    stall_len = $urandom_range(0, 1) ? 0 : idle_len();
                    if ($urandom_range(0, 39) == 0)
                        calm = $urandom_range(30, 120);
                end
                result_stall <= (stall_len != 0);
                if (stall_len == 0)
                    stall_len = 1;
                repeat (stall_len) @(posedge clk);
                cycles_seen += stall_len;
            end
        end
    end

endmodule

// File: sim.f
src/bttm_pkg.sv
src/bttm_ram.sv
src/bttm_ring.sv
src/bttm_front.sv
src/bttm_queue.sv
src/bttm_back.sv
src/battery_temp_button_monitor.sv
tb/bttm_checker.sv
tb/battery_temp_button_monitor_tb.sv
